// ----- rtl/bmp_pkg.sv -----
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared sizes, codes and types of the blocking message port.
// ----------------------------------------------------------------------------
package bmp_pkg;

    // sizes of the stores and of the fields
    localparam int QUEUE_DEPTH  = 16;
    localparam int WAIT_DEPTH   = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int ID_BITS      = 8;
    localparam int CAP_W        = 5;
    localparam int KIND_W       = 3;

    // pointer and count widths
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int WPTR_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int WCNT_W = $clog2(WAIT_DEPTH + 1);
    localparam int CMP_W  = (QCNT_W > CAP_W) ? QCNT_W : CAP_W;

    // stream data widths, padded to whole bytes
    localparam int S_USED_W   = ID_BITS + PAYLOAD_BITS;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;
    localparam int M_USED_W   = 2 * ID_BITS + PAYLOAD_BITS;
    localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;

    typedef enum logic
    {
        OP_SEND = 1'b0,
        OP_RECV = 1'b1
    } op_t;

    typedef enum logic [KIND_W-1:0]
    {
        KIND_DONE    = 3'd0,
        KIND_BLOCKED = 3'd1,
        KIND_WAKE_RX = 3'd2,
        KIND_WAKE_TX = 3'd3,
        KIND_FULL    = 3'd4
    } kind_t;

    // one result item
    typedef struct packed
    {
        logic [ID_BITS-1:0]      target_id;
        kind_t                   kind;
        logic [PAYLOAD_BITS-1:0] packet_out;
        logic [ID_BITS-1:0]      from_id;
        logic                    last;
    } result_t;

    // the results of one request, caller first
    typedef struct packed
    {
        result_t first;
        result_t second;
        logic    two;
    } result_pair_t;

    // wrapping pointer steps
    function automatic logic [QPTR_W-1:0] qptr_inc(input logic [QPTR_W-1:0] ptr);
        logic [QPTR_W-1:0] res;
        if (ptr == QPTR_W'(QUEUE_DEPTH - 1))
            res = '0;
        else
            res = ptr + 1'b1;
        return res;
    endfunction

    function automatic logic [WPTR_W-1:0] wptr_inc(input logic [WPTR_W-1:0] ptr);
        logic [WPTR_W-1:0] res;
        if (ptr == WPTR_W'(WAIT_DEPTH - 1))
            res = '0;
        else
            res = ptr + 1'b1;
        return res;
    endfunction

endpackage

// ----- rtl/bmp_core.sv -----
// ----------------------------------------------------------------------------
// bmp_core
// Mailbox state: packet queue, receiver wait list, sender wait list and the
// capacity register, with the single-pass request decision.
// ----------------------------------------------------------------------------
module bmp_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bmp_pkg::CAP_W-1:0]        cfg_data,
    input  logic                             fire,
    input  bmp_pkg::op_t                     op,
    input  logic [bmp_pkg::ID_BITS-1:0]      caller_id,
    input  logic [bmp_pkg::PAYLOAD_BITS-1:0] payload,
    output bmp_pkg::result_pair_t            results
);

    // capacity register
    logic [bmp_pkg::CAP_W-1:0] cap_reg;

    // packet queue
    logic [bmp_pkg::ID_BITS-1:0]      q_id_reg  [bmp_pkg::QUEUE_DEPTH];
    logic [bmp_pkg::PAYLOAD_BITS-1:0] q_pay_reg [bmp_pkg::QUEUE_DEPTH];
    logic [bmp_pkg::QPTR_W-1:0]       q_head_reg, q_tail_reg;
    logic [bmp_pkg::QCNT_W-1:0]       q_cnt_reg, q_cnt_next;

    // receiver wait list
    logic [bmp_pkg::ID_BITS-1:0]      rw_id_reg [bmp_pkg::WAIT_DEPTH];
    logic [bmp_pkg::WPTR_W-1:0]       rw_head_reg, rw_tail_reg;
    logic [bmp_pkg::WCNT_W-1:0]       rw_cnt_reg, rw_cnt_next;

    // sender wait list
    logic [bmp_pkg::ID_BITS-1:0]      sw_id_reg  [bmp_pkg::WAIT_DEPTH];
    logic [bmp_pkg::PAYLOAD_BITS-1:0] sw_pay_reg [bmp_pkg::WAIT_DEPTH];
    logic [bmp_pkg::WPTR_W-1:0]       sw_head_reg, sw_tail_reg;
    logic [bmp_pkg::WCNT_W-1:0]       sw_cnt_reg, sw_cnt_next;

    // decision signals
    logic                             q_push, q_pop, rw_push, rw_pop, sw_push, sw_pop;
    logic [bmp_pkg::ID_BITS-1:0]      q_push_id;
    logic [bmp_pkg::PAYLOAD_BITS-1:0] q_push_pay;
    logic [bmp_pkg::CMP_W-1:0]        cap_ext, cap_eff;
    logic                             q_room, q_any, rw_any, rw_full, sw_any, sw_full;
    bmp_pkg::result_pair_t            res;

    // heads of the stores
    logic [bmp_pkg::ID_BITS-1:0]      q_head_id, rw_head_id, sw_head_id;
    logic [bmp_pkg::PAYLOAD_BITS-1:0] q_head_pay, sw_head_pay;

    assign q_head_id   = q_id_reg[q_head_reg];
    assign q_head_pay  = q_pay_reg[q_head_reg];
    assign rw_head_id  = rw_id_reg[rw_head_reg];
    assign sw_head_id  = sw_id_reg[sw_head_reg];
    assign sw_head_pay = sw_pay_reg[sw_head_reg];

    // capacity clamped to the queue depth
    assign cap_ext = bmp_pkg::CMP_W'(cap_reg);
    assign cap_eff = (cap_ext > bmp_pkg::CMP_W'(bmp_pkg::QUEUE_DEPTH))
                     ? bmp_pkg::CMP_W'(bmp_pkg::QUEUE_DEPTH) : cap_ext;

    assign q_room  = bmp_pkg::CMP_W'(q_cnt_reg) < cap_eff;
    assign q_any   = q_cnt_reg != '0;
    assign rw_any  = rw_cnt_reg != '0;
    assign rw_full = rw_cnt_reg == bmp_pkg::WCNT_W'(bmp_pkg::WAIT_DEPTH);
    assign sw_any  = sw_cnt_reg != '0;
    assign sw_full = sw_cnt_reg == bmp_pkg::WCNT_W'(bmp_pkg::WAIT_DEPTH);

    // request decision
    always_comb
    begin
        q_push     = 1'b0;
        q_pop      = 1'b0;
        rw_push    = 1'b0;
        rw_pop     = 1'b0;
        sw_push    = 1'b0;
        sw_pop     = 1'b0;
        q_push_id  = caller_id;
        q_push_pay = payload;

        res.first.target_id  = caller_id;
        res.first.kind       = bmp_pkg::KIND_DONE;
        res.first.packet_out = '0;
        res.first.from_id    = '0;
        res.first.last       = 1'b1;
        res.second.target_id  = sw_head_id;
        res.second.kind       = bmp_pkg::KIND_WAKE_TX;
        res.second.packet_out = '0;
        res.second.from_id    = '0;
        res.second.last       = 1'b1;
        res.two               = 1'b0;

        case (op)
            bmp_pkg::OP_SEND:
            begin
                if (rw_any)
                begin
                    rw_pop                = 1'b1;
                    res.first.last        = 1'b0;
                    res.second.target_id  = rw_head_id;
                    res.second.kind       = bmp_pkg::KIND_WAKE_RX;
                    res.second.packet_out = payload;
                    res.second.from_id    = caller_id;
                    res.two               = 1'b1;
                end
                else if (q_room)
                begin
                    q_push = 1'b1;
                end
                else if (sw_full)
                begin
                    res.first.kind = bmp_pkg::KIND_FULL;
                end
                else
                begin
                    sw_push        = 1'b1;
                    res.first.kind = bmp_pkg::KIND_BLOCKED;
                end
            end
            bmp_pkg::OP_RECV:
            begin
                if (q_any)
                begin
                    q_pop                = 1'b1;
                    res.first.packet_out = q_head_pay;
                    res.first.from_id    = q_head_id;
                    if (sw_any)
                    begin
                        // refill from the oldest blocked sender
                        sw_pop         = 1'b1;
                        q_push         = 1'b1;
                        q_push_id      = sw_head_id;
                        q_push_pay     = sw_head_pay;
                        res.first.last = 1'b0;
                        res.two        = 1'b1;
                    end
                end
                else if (sw_any)
                begin
                    sw_pop               = 1'b1;
                    res.first.packet_out = sw_head_pay;
                    res.first.from_id    = sw_head_id;
                    res.first.last       = 1'b0;
                    res.two              = 1'b1;
                end
                else if (rw_full)
                begin
                    res.first.kind = bmp_pkg::KIND_FULL;
                end
                else
                begin
                    rw_push        = 1'b1;
                    res.first.kind = bmp_pkg::KIND_BLOCKED;
                end
            end
            default:
            begin
                res.first.kind = bmp_pkg::KIND_FULL;
            end
        endcase
    end

    assign results = res;

    // count updates
    always_comb
    begin
        q_cnt_next  = q_cnt_reg;
        rw_cnt_next = rw_cnt_reg;
        sw_cnt_next = sw_cnt_reg;
        if (q_push && !q_pop)
            q_cnt_next = q_cnt_reg + 1'b1;
        else if (q_pop && !q_push)
            q_cnt_next = q_cnt_reg - 1'b1;
        if (rw_push)
            rw_cnt_next = rw_cnt_reg + 1'b1;
        else if (rw_pop)
            rw_cnt_next = rw_cnt_reg - 1'b1;
        if (sw_push)
            sw_cnt_next = sw_cnt_reg + 1'b1;
        else if (sw_pop)
            sw_cnt_next = sw_cnt_reg - 1'b1;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= '0;
            q_head_reg  <= '0;
            q_tail_reg  <= '0;
            q_cnt_reg   <= '0;
            rw_head_reg <= '0;
            rw_tail_reg <= '0;
            rw_cnt_reg  <= '0;
            sw_head_reg <= '0;
            sw_tail_reg <= '0;
            sw_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_data;
            if (fire)
            begin
                q_cnt_reg  <= q_cnt_next;
                rw_cnt_reg <= rw_cnt_next;
                sw_cnt_reg <= sw_cnt_next;
                if (q_push)
                    q_tail_reg <= bmp_pkg::qptr_inc(q_tail_reg);
                if (q_pop)
                    q_head_reg <= bmp_pkg::qptr_inc(q_head_reg);
                if (rw_push)
                    rw_tail_reg <= bmp_pkg::wptr_inc(rw_tail_reg);
                if (rw_pop)
                    rw_head_reg <= bmp_pkg::wptr_inc(rw_head_reg);
                if (sw_push)
                    sw_tail_reg <= bmp_pkg::wptr_inc(sw_tail_reg);
                if (sw_pop)
                    sw_head_reg <= bmp_pkg::wptr_inc(sw_head_reg);
            end
        end
    end

    // store contents, written at the tails
    always_ff @(posedge clk)
    begin
        if (fire && q_push)
        begin
            q_id_reg[q_tail_reg]  <= q_push_id;
            q_pay_reg[q_tail_reg] <= q_push_pay;
        end
        if (fire && rw_push)
            rw_id_reg[rw_tail_reg] <= caller_id;
        if (fire && sw_push)
        begin
            sw_id_reg[sw_tail_reg]  <= caller_id;
            sw_pay_reg[sw_tail_reg] <= payload;
        end
    end

    // receivers only wait when nothing is queued and no sender waits
    a_rx_wait_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (rw_cnt_reg != '0) |-> (q_cnt_reg == '0 && sw_cnt_reg == '0))
        else $error("receivers wait while packets or senders are available");

    // queue never exceeds its depth
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= bmp_pkg::QCNT_W'(bmp_pkg::QUEUE_DEPTH))
        else $error("packet queue count beyond depth");

endmodule

// ----- rtl/bmp_out_buf.sv -----
// ----------------------------------------------------------------------------
// bmp_out_buf
// Two-entry result register: holds the caller result and any wake-up
// result of one request and hands them out in order.
// ----------------------------------------------------------------------------
module bmp_out_buf
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  bmp_pkg::result_pair_t results,
    output logic                  free,
    output logic                  out_valid,
    input  logic                  out_ready,
    output bmp_pkg::result_t      out_result
);

    logic             out0_vld_reg, out1_vld_reg;
    bmp_pkg::result_t out0_reg, out1_reg;
    logic             take;

    assign take       = out0_vld_reg && out_ready;
    assign free       = !out0_vld_reg || (!out1_vld_reg && out_ready);
    assign out_valid  = out0_vld_reg;
    assign out_result = out0_reg;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out0_vld_reg <= 1'b0;
            out1_vld_reg <= 1'b0;
        end
        else if (load)
        begin
            out0_vld_reg <= 1'b1;
            out1_vld_reg <= results.two;
        end
        else if (take)
        begin
            out0_vld_reg <= out1_vld_reg;
            out1_vld_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out0_reg <= results.first;
            out1_reg <= results.second;
        end
        else if (take)
        begin
            out0_reg <= out1_reg;
        end
    end

    // a held wake-up result always has a caller result in front of it
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out1_vld_reg |-> (out0_vld_reg && !out0_reg.last && out1_reg.last))
        else $error("wake-up result held without its caller result");

    // a non-final result is always followed by a buffered one
    a_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (out0_vld_reg && !out0_reg.last) |-> out1_vld_reg)
        else $error("non-final result without a following result");

endmodule

// ----- rtl/blocking_message_port.sv -----
// ----------------------------------------------------------------------------
// blocking_message_port
// Mailbox port with a bounded packet queue and receiver and sender wait lists.
// ----------------------------------------------------------------------------
// flow: a request is registered at acceptance, decided from the request register
//   once the result register is free, and its first result is presented from it
// throughput: one request per cycle if it gives one result and m_tready is high; one
//   with two results holds the next until its first is taken (single result port)
// reset: clears capacity, pointers, counts and valid flags; stores need no clearing
// ----------------------------------------------------------------------------
module blocking_message_port
(
    input  logic                          clk,
    input  logic                          rst_n,
    // capacity register
    input  logic                          cfg_we,
    input  logic [bmp_pkg::CAP_W-1:0]     cfg_data,
    // requests
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bmp_pkg::S_TDATA_W-1:0] s_tdata,  // caller_id, payload
    input  logic                          s_tuser,  // op
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bmp_pkg::M_TDATA_W-1:0] m_tdata,  // target_id, packet_out, from_id
    output logic [bmp_pkg::KIND_W-1:0]    m_tuser,  // kind
    output logic                          m_tlast
);

    logic                             in_vld_reg;
    bmp_pkg::op_t                     in_op_reg;
    logic [bmp_pkg::ID_BITS-1:0]      in_id_reg;
    logic [bmp_pkg::PAYLOAD_BITS-1:0] in_pay_reg;
    logic                             fire, out_free;
    bmp_pkg::result_pair_t            results;
    bmp_pkg::result_t                 out_result;

    assign fire     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || fire;

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_tready)
            in_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg  <= bmp_pkg::op_t'(s_tuser);
            in_id_reg  <= s_tdata[bmp_pkg::ID_BITS-1:0];
            in_pay_reg <= s_tdata[bmp_pkg::S_USED_W-1:bmp_pkg::ID_BITS];
        end
    end

    // mailbox state and decision
    bmp_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .op        (in_op_reg),
        .caller_id (in_id_reg),
        .payload   (in_pay_reg),
        .results   (results)
    );

    // result register
    bmp_out_buf u_out_buf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .results    (results),
        .free       (out_free),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    // result packing
    assign m_tdata = bmp_pkg::M_TDATA_W'({out_result.from_id, out_result.packet_out,
                                          out_result.target_id});
    assign m_tuser = out_result.kind;
    assign m_tlast = out_result.last;

endmodule
